// ===== rtl/mcd_pkg.sv =====
// Shared constants, frame type and helper functions for the maze carver.
package mcd_pkg;

   localparam int MAX_SIDE   = 64;
   localparam int GRID_CELLS = 4096;
   localparam int COORD_W    = 6;
   localparam int SIDE_W     = 7;
   localparam int CELL_AW    = $clog2(GRID_CELLS);
   localparam int DEPTH_W    = 13;
   localparam int CELL_W     = 5;
   localparam int VISITED    = 4;

   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   localparam logic [2:0] EV_CARVED   = 3'd0;
   localparam logic [2:0] EV_BACKTRACK = 3'd1;
   localparam logic [2:0] EV_FINISHED = 3'd2;
   localparam logic [2:0] EV_STARTED  = 3'd3;
   localparam logic [2:0] EV_REJECTED = 3'd4;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [2:0]         next;
      logic [3:0][1:0]    order;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } frame_type;

   localparam int FRAME_W = $bits(frame_type);

   // Zero reads as one, anything past the largest side saturates.
   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v == '0) r = SIDE_W'(1);
      if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
      return r;
   endfunction

   // Fisher-Yates order from the three swap picks.
   function automatic logic [3:0][1:0] shuffle(input logic [1:0] p4, input logic [1:0] p3,
                                               input logic p2);
      logic [3:0][1:0] o;
      logic [1:0]      t;
      logic [1:0]      j3;
      o = {DIR_W, DIR_S, DIR_E, DIR_N};
      t = o[3]; o[3] = o[p4]; o[p4] = t;
      j3 = (p3 == 2'd3) ? 2'd0 : p3;
      t = o[2]; o[2] = o[j3]; o[j3] = t;
      t = o[1]; o[1] = o[{1'b0, p2}]; o[{1'b0, p2}] = t;
      return o;
   endfunction

endpackage

// ===== rtl/mcd_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module mcd_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mcd_addr_unit.sv =====
// Shared cell address unit: registered y * width + x, wrapped to the cell store.
module mcd_addr_unit
   import mcd_pkg::*;
(
   input  logic               clock,
   input  logic [SIDE_W-1:0]  x,
   input  logic [SIDE_W-1:0]  y,
   input  logic [SIDE_W-1:0]  w,
   output logic [CELL_AW-1:0] addr
);

   logic [2*SIDE_W-1:0] prod;
   logic [2*SIDE_W-1:0] sum;
   logic [CELL_AW-1:0]  addr_ff;

   always_comb begin
      prod = y * w;
      sum  = prod + {{SIDE_W{1'b0}}, x};
   end

   always_ff @(posedge clock) begin
      addr_ff <= sum[CELL_AW-1:0];
   end

   assign addr = addr_ff;

endmodule

// ===== rtl/maze_carver_dfs.sv =====
// Depth-first maze carver: sequencer around shared address unit, cell RAM and frame stack RAM.
// Start clears the whole cell store (GRID_CELLS cells, 4096) to zero, then marks the start cell visited
//   and pushes it; a start outside the grid is rejected. Step loads the top frame and tries its directions
//   in order, paced by the one cell RAM port: an off-grid or visited neighbor moves on to the next try,
//   the carving try writes both cells and pushes the neighbor, and a fully tried frame is popped.
// Result waits in the output register while the next is taken; reset: empty stack, 16 x 16.
module maze_carver_dfs
   import mcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_x[5:0], start_y[11:6], pick_of_four[13:12], pick_of_three[15:14],
   // pick_of_two[16], zero pad[23:17]
   input  logic [23:0] req_tdata,
   // operation[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_x[5:0], cell_y[11:6], carve_dir[13:12], stack_depth[26:14],
   // dead_end_count[39:27], junction_count[52:40], zero pad[55:53]
   output logic [55:0] rsp_tdata,
   // event_res[2:0]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_addr,
   input  logic [6:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_FRAME_LD, S_TRY, S_NB_RD, S_NB_CHK, S_OWN_RD, S_OWN_WR,
      S_NB_WR, S_PUSH, S_CLEAR, S_START_WR, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [SIDE_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic [DEPTH_W-1:0]  top_ff, top_in, dead_ff, dead_in, junc_ff, junc_in;
   logic [CELL_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   frame_type           frame_ff, frame_in;
   logic [COORD_W-1:0]  nb_x_ff, nb_x_in, nb_y_ff, nb_y_in;
   logic [COORD_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic [CELL_AW-1:0]  nb_addr_ff, nb_addr_in;
   logic [CELL_W-1:0]   nb_val_ff, nb_val_in;
   logic [1:0]          dir_ff, dir_in;
   logic [3:0][1:0]     order_ff, order_in;
   logic [2:0]          ev_ff, ev_in;
   logic [COORD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0]          cd_ff, cd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [55:0]         rsp_data_ff, rsp_data_in;
   logic [2:0]          rsp_user_ff, rsp_user_in;

   logic [SIDE_W-1:0]   w_eff, h_eff;
   logic [SIDE_W-1:0]   op_x, op_y;
   logic [CELL_AW-1:0]  addr_q;
   logic                cell_we;
   logic [CELL_AW-1:0]  cell_waddr;
   logic [CELL_W-1:0]   cell_wdata, cell_rd;
   logic                stk_we;
   logic [CELL_AW-1:0]  stk_waddr, stk_raddr;
   frame_type           stk_wdata, stk_rd;

   // neighbor of the top frame for the direction under test
   logic [1:0]          try_dir;
   logic [SIDE_W-1:0]   try_x, try_y;
   logic                try_off;

   // passage bookkeeping for the cell being written
   logic [3:0]          upd_val;
   logic [1:0]          upd_dir;
   logic [2:0]          upd_deg;
   logic [DEPTH_W-1:0]  upd_dead, upd_junc;

   logic [COORD_W-1:0]  req_sx, req_sy;

   assign w_eff = eff_side(width_ff);
   assign h_eff = eff_side(height_ff);
   assign req_sx = req_tdata[5:0];
   assign req_sy = req_tdata[11:6];

   always_comb begin
      try_dir = frame_ff.order[frame_ff.next[1:0]];
      try_x   = {1'b0, frame_ff.x};
      try_y   = {1'b0, frame_ff.y};
      case (try_dir)
         DIR_N:   try_y = try_y - SIDE_W'(1);
         DIR_E:   try_x = try_x + SIDE_W'(1);
         DIR_S:   try_y = try_y + SIDE_W'(1);
         DIR_W:   try_x = try_x - SIDE_W'(1);
         default: try_x = try_x;
      endcase
      try_off = (try_dir == DIR_N && frame_ff.y == '0) ||
                (try_dir == DIR_W && frame_ff.x == '0) ||
                (try_x >= w_eff) || (try_y >= h_eff);
   end

   // address unit operands: neighbor while trying, start cell while clearing or writing the start, else own cell
   always_comb begin
      case (state_ff)
         S_TRY: begin
            op_x = try_x;
            op_y = try_y;
         end
         S_CLEAR, S_START_WR: begin
            op_x = {1'b0, sx_ff};
            op_y = {1'b0, sy_ff};
         end
         default: begin
            op_x = {1'b0, frame_ff.x};
            op_y = {1'b0, frame_ff.y};
         end
      endcase
   end

   mcd_addr_unit u_addr (
      .clock (clock),
      .x     (op_x),
      .y     (op_y),
      .w     (w_eff),
      .addr  (addr_q)
   );

   mcd_ram #(.DATA_W(CELL_W), .DEPTH(GRID_CELLS)) u_cells (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (addr_q),
      .rd_data (cell_rd)
   );

   assign stk_raddr = CELL_AW'(top_ff - DEPTH_W'(1));

   mcd_ram #(.DATA_W(FRAME_W), .DEPTH(GRID_CELLS)) u_frames (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

   // dead-end / junction update when one passage bit is added
   always_comb begin
      if (state_ff == S_NB_WR) begin
         upd_val = nb_val_ff[3:0];
         upd_dir = dir_ff + 2'd2;
      end else begin
         upd_val = cell_rd[3:0];
         upd_dir = dir_ff;
      end
      upd_deg  = 3'($countones(upd_val));
      upd_dead = dead_ff;
      upd_junc = junc_ff;
      if (!upd_val[upd_dir]) begin
         if (upd_deg == 3'd1 && dead_ff != '0) upd_dead = dead_ff - DEPTH_W'(1);
         if (upd_deg == 3'd0) upd_dead = dead_ff + DEPTH_W'(1);
         if (upd_deg == 3'd2) upd_junc = junc_ff + DEPTH_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      top_in       = top_ff;
      dead_in      = dead_ff;
      junc_in      = junc_ff;
      clr_cnt_in   = clr_cnt_ff;
      frame_in     = frame_ff;
      nb_x_in      = nb_x_ff;
      nb_y_in      = nb_y_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      nb_addr_in   = nb_addr_ff;
      nb_val_in    = nb_val_ff;
      dir_in       = dir_ff;
      order_in     = order_ff;
      ev_in        = ev_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cd_in        = cd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      cell_we      = 1'b0;
      cell_waddr   = addr_q;
      cell_wdata   = '0;
      stk_we       = 1'b0;
      stk_waddr    = stk_raddr;
      stk_wdata    = frame_ff;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (csr_valid) begin
         case (csr_addr)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sx_in    = req_sx;
               sy_in    = req_sy;
               order_in = shuffle(req_tdata[13:12], req_tdata[15:14], req_tdata[16]);
               cx_in    = '0;
               cy_in    = '0;
               cd_in    = DIR_N;
               if (req_tuser == OP_START) begin
                  cx_in = req_sx;
                  cy_in = req_sy;
                  if ({1'b0, req_sx} >= w_eff || {1'b0, req_sy} >= h_eff) begin
                     ev_in    = EV_REJECTED;
                     state_in = S_DONE;
                  end else begin
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
               end else if (top_ff == '0) begin
                  ev_in    = EV_FINISHED;
                  state_in = S_DONE;
               end else begin
                  state_in = S_FRAME_LD;
               end
            end
         end
         S_FRAME_LD: begin
            frame_in = stk_rd;
            cx_in    = stk_rd.x;
            cy_in    = stk_rd.y;
            state_in = S_TRY;
         end
         S_TRY: begin
            if (frame_ff.next[2]) begin
               top_in   = top_ff - DEPTH_W'(1);
               ev_in    = EV_BACKTRACK;
               state_in = S_DONE;
            end else begin
               frame_in.next = frame_ff.next + 3'd1;
               dir_in        = try_dir;
               nb_x_in       = try_x[COORD_W-1:0];
               nb_y_in       = try_y[COORD_W-1:0];
               if (!try_off) state_in = S_NB_RD;
            end
         end
         S_NB_RD: begin
            // address unit now holds the neighbor; own cell address follows
            nb_addr_in = addr_q;
            state_in   = S_NB_CHK;
         end
         S_NB_CHK: begin
            nb_val_in = cell_rd;
            if (cell_rd[VISITED]) begin
               state_in = S_TRY;
            end else begin
               state_in = S_OWN_RD;
            end
         end
         S_OWN_RD: begin
            state_in = S_OWN_WR;
         end
         S_OWN_WR: begin
            cell_we    = 1'b1;
            cell_waddr = addr_q;
            cell_wdata = cell_rd | (CELL_W'(1) << dir_ff);
            dead_in    = upd_dead;
            junc_in    = upd_junc;
            state_in   = S_NB_WR;
         end
         S_NB_WR: begin
            cell_we    = 1'b1;
            cell_waddr = nb_addr_ff;
            cell_wdata = nb_val_ff | (CELL_W'(1) << VISITED) |
                         (CELL_W'(1) << (dir_ff + 2'd2));
            dead_in    = upd_dead;
            junc_in    = upd_junc;
            // save the advanced try index of the current frame
            stk_we     = 1'b1;
            stk_waddr  = stk_raddr;
            stk_wdata  = frame_ff;
            state_in   = S_PUSH;
         end
         S_PUSH: begin
            stk_waddr = top_ff[CELL_AW-1:0];
            stk_wdata = '{next: 3'd0, order: order_ff, y: nb_y_ff, x: nb_x_ff};
            if (top_ff < DEPTH_W'(GRID_CELLS)) begin
               stk_we = 1'b1;
               top_in = top_ff + DEPTH_W'(1);
            end
            ev_in    = EV_CARVED;
            cd_in    = dir_ff;
            state_in = S_DONE;
         end
         S_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_cnt_ff;
            cell_wdata = '0;
            clr_cnt_in = clr_cnt_ff + CELL_AW'(1);
            if (clr_cnt_ff == '1) state_in = S_START_WR;
         end
         S_START_WR: begin
            cell_we    = 1'b1;
            cell_waddr = addr_q;
            cell_wdata = CELL_W'(1) << VISITED;
            stk_we     = 1'b1;
            stk_waddr  = '0;
            stk_wdata  = '{next: 3'd0, order: order_ff, y: sy_ff, x: sx_ff};
            top_in     = DEPTH_W'(1);
            dead_in    = '0;
            junc_in    = '0;
            ev_in      = EV_STARTED;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = ev_ff;
               rsp_data_in  = {3'b000, junc_ff, dead_ff, top_ff, cd_ff, cy_ff, cx_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= SIDE_W'(16);
         height_ff    <= SIDE_W'(16);
         top_ff       <= '0;
         dead_ff      <= '0;
         junc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         top_ff       <= top_in;
         dead_ff      <= dead_in;
         junc_ff      <= junc_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_cnt_ff   <= clr_cnt_in;
         frame_ff     <= frame_in;
         nb_x_ff      <= nb_x_in;
         nb_y_ff      <= nb_y_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         nb_addr_ff   <= nb_addr_in;
         nb_val_ff    <= nb_val_in;
         dir_ff       <= dir_in;
         order_ff     <= order_in;
         ev_ff        <= ev_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         cd_ff        <= cd_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_user_ff  <= rsp_user_in;
      end
   end

   // nothing is taken while reset is held
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = !reset;

endmodule
